>>> rtl/tsv_pkg.sv
// Shared types for the square-root spiral vertex generator.
// Used by the iterative root/divide unit and the top-level sequencer.
package tsv_pkg;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  typedef enum logic [1:0] {
    REG_CENTER_X   = 2'd0,
    REG_CENTER_Y   = 2'd1,
    REG_LEG_LENGTH = 2'd2,
    REG_STEP_LIMIT = 2'd3
  } reg_idx_e;

  localparam int unsigned UNIT_STEPS = 32;

endpackage

>>> rtl/tsv_iter_unit.sv
// Shift-subtract unit: 64-bit integer square root or 64/32 division, one bit per cycle.
// Depends on tsv_pkg for the request struct and operation codes.
module tsv_iter_unit import tsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  unit_req_t   req_i,
  input  logic [63:0] n_i,
  input  logic [31:0] d_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  logic        busy_q, done_q;
  unit_op_e    op_q;
  logic [4:0]  cnt_q;
  logic [34:0] rem_q;
  logic [63:0] n_q;
  logic [31:0] root_q, d_q;

  logic [34:0] shifted, sub;
  logic [35:0] diff;
  logic        fits;

  always_comb begin
    if (op_q == OP_SQRT) begin
      shifted = {rem_q[32:0], n_q[63:62]};
      sub     = {1'b0, root_q, 2'b01};
    end else begin
      shifted = {rem_q[33:0], n_q[63]};
      sub     = {3'b000, d_q};
    end
    diff = {1'b0, shifted} - {1'b0, sub};
    fits = !diff[35];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= 5'(UNIT_STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      root_q <= '0;
      d_q    <= d_i;
      if (req_i.op == OP_SQRT) begin
        rem_q <= '0;
        n_q   <= n_i;
      end else begin
        // high half is already below the divisor, so 32 quotient bits suffice
        rem_q <= {3'b000, n_i[63:32]};
        n_q   <= {n_i[31:0], 32'd0};
      end
    end else if (busy_q) begin
      rem_q  <= fits ? diff[34:0] : shifted;
      root_q <= {root_q[30:0], fits};
      n_q    <= (op_q == OP_SQRT) ? {n_q[61:0], 2'b00} : {n_q[62:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = root_q;

endmodule

>>> rtl/theodorus_spiral_vertex_generator_core.sv
// Square-root spiral vertex generator: top-level sequencer, shared multiplier, point state.
// Depends on tsv_pkg and tsv_iter_unit.
//
// A restart beat, or an advance beat once the step limit is reached, returns its result in
// the cycle after it is taken. A moving advance runs these steps one after another: range
// reduction, which halves the center offset until it fits (at most once at 32-bit
// coordinates), three states to form the squared magnitude, the square root, two divisions
// each behind a multiply state and a launch state, and a state to update the point. The
// root and both divisions run on the single shift-subtract unit. An advance from a point
// that sits on the center returns once the square root is done, without moving the point.
// The input is not ready while a step is in work or a result beat waits on the output.
module theodorus_spiral_vertex_generator_core import tsv_pkg::*; #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [0] restart
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,   // from_x, from_y, to_x, to_y (32 bits each)
  output logic [0:0]   m_axis_tuser_o,   // [0] finished
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = ((CW > 32) ? CW : 32) + 1;
  localparam int unsigned SW = DW + 1;
  localparam logic signed [SW-1:0] MAXV = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SHIFT, ST_SQA, ST_SQB, ST_SQC, ST_ROOT, ST_MULY,
    ST_DIVX_GO, ST_DIVX, ST_MULX, ST_DIVY_GO, ST_DIVY, ST_FIN
  } state_e;

  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    begin
      if (v > MAXV) r = MAXV;
      else if (v < MINV) r = MINV;
      else r = v;
      return r[CW-1:0];
    end
  endfunction

  function automatic logic signed [SW-1:0] ext_c(input logic signed [CW-1:0] v);
    return {{(SW-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic signed [SW-1:0] ext_32(input logic signed [31:0] v);
    return {{(SW-32){v[31]}}, v};
  endfunction

  localparam logic signed [31:0] RST_CX = 32'sd19660800;
  localparam logic signed [31:0] RST_CY = 32'sd19660800;
  localparam logic [30:0]        RST_LEG = 31'd3932160;
  localparam logic signed [CW-1:0] RST_PX = sat(ext_32(RST_CX));
  localparam logic signed [CW-1:0] RST_PY = sat(ext_32(RST_CY) - {{(SW-31){1'b0}}, RST_LEG});

  logic signed [31:0] center_x_q, center_y_q;
  logic [30:0]        leg_q;
  logic [15:0]        limit_q, count_q;
  logic signed [CW-1:0] px_q, py_q;

  state_e      state_q;
  logic [DW-1:0] ax_q, ay_q;
  logic        dxneg_q, dyneg_q;
  logic [61:0] mul_q, acc_q;
  logic [31:0] mag_q, qx_q;
  logic        m_valid_q, fin_q;
  logic [31:0] ofx_q, ofy_q, otx_q, oty_q;

  unit_req_t   req;
  logic [63:0] unit_n;
  logic        unit_done;
  logic [31:0] unit_res;
  logic [30:0] mul_a, mul_b;

  logic in_acc, restart;
  logic signed [SW-1:0] dx, dy, stepx, stepy;
  logic signed [CW-1:0] nx, ny, first_py;

  assign s_axis_tready_o = (state_q == ST_IDLE) && !m_valid_q;
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign restart = s_axis_tdata_i[0];

  always_comb begin
    dx = ext_c(px_q) - ext_32(center_x_q);
    dy = ext_c(py_q) - ext_32(center_y_q);
    first_py = sat(ext_32(center_y_q) - {{(SW-31){1'b0}}, leg_q});
    stepx = {{(SW-32){1'b0}}, qx_q};
    if (!dyneg_q) stepx = -stepx;
    stepy = {{(SW-32){1'b0}}, unit_res};
    if (dxneg_q) stepy = -stepy;
    nx = sat(ext_c(px_q) + stepx);
    ny = sat(ext_c(py_q) + stepy);
  end

  always_comb begin
    req    = '{start: 1'b0, op: OP_DIV};
    unit_n = {2'b00, mul_q} + {33'd0, mag_q[31:1]};
    mul_a  = ax_q[30:0];
    mul_b  = leg_q;
    unique case (state_q)
      ST_SQA:  mul_b = ax_q[30:0];
      ST_SQB: begin
        mul_a = ay_q[30:0];
        mul_b = ay_q[30:0];
      end
      ST_SQC: begin
        req    = '{start: 1'b1, op: OP_SQRT};
        unit_n = {2'b00, acc_q} + {2'b00, mul_q};
      end
      ST_MULY:    mul_a = ay_q[30:0];
      ST_DIVX_GO: req = '{start: 1'b1, op: OP_DIV};
      ST_DIVY_GO: req = '{start: 1'b1, op: OP_DIV};
      default: ;
    endcase
  end

  tsv_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .n_i    (unit_n),
    .d_i    (mag_q),
    .done_o (unit_done),
    .res_o  (unit_res)
  );

  always_ff @(posedge clk_i) begin
    mul_q <= 62'(mul_a) * 62'(mul_b);
    if (state_q == ST_SQB) acc_q <= mul_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= RST_CX;
      center_y_q <= RST_CY;
      leg_q      <= RST_LEG;
      limit_q    <= 16'd16;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CENTER_X:   center_x_q <= cfg_data_i;
        REG_CENTER_Y:   center_y_q <= cfg_data_i;
        REG_LEG_LENGTH: leg_q      <= cfg_data_i[30:0];
        REG_STEP_LIMIT: limit_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      px_q      <= RST_PX;
      py_q      <= RST_PY;
      count_q   <= 16'd1;
    end else begin
      if (m_valid_q && m_axis_tready_i) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (restart) begin
              px_q      <= sat(ext_32(center_x_q));
              py_q      <= first_py;
              count_q   <= 16'd1;
              ofx_q     <= center_x_q;
              ofy_q     <= center_y_q;
              otx_q     <= 32'(ext_c(sat(ext_32(center_x_q))));
              oty_q     <= 32'(ext_c(first_py));
              fin_q     <= 1'b0;
              m_valid_q <= 1'b1;
            end else if (count_q >= limit_q) begin
              ofx_q     <= 32'(ext_c(px_q));
              ofy_q     <= 32'(ext_c(py_q));
              otx_q     <= 32'(ext_c(px_q));
              oty_q     <= 32'(ext_c(py_q));
              fin_q     <= 1'b1;
              m_valid_q <= 1'b1;
            end else begin
              dxneg_q <= dx[SW-1];
              dyneg_q <= dy[SW-1];
              ax_q    <= dx[SW-1] ? DW'(-dx) : DW'(dx);
              ay_q    <= dy[SW-1] ? DW'(-dy) : DW'(dy);
              state_q <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          // halve both until the larger fits in 31 bits
          if ((ax_q[DW-1:31] | ay_q[DW-1:31]) != '0) begin
            ax_q <= ax_q >> 1;
            ay_q <= ay_q >> 1;
          end else begin
            state_q <= ST_SQA;
          end
        end
        ST_SQA: state_q <= ST_SQB;
        ST_SQB: state_q <= ST_SQC;
        ST_SQC: state_q <= ST_ROOT;
        ST_ROOT: begin
          if (unit_done) begin
            mag_q <= unit_res;
            if (unit_res == '0) begin
              // point at center: no move, but the step still counts
              ofx_q     <= 32'(ext_c(px_q));
              ofy_q     <= 32'(ext_c(py_q));
              otx_q     <= 32'(ext_c(px_q));
              oty_q     <= 32'(ext_c(py_q));
              fin_q     <= 1'b0;
              m_valid_q <= 1'b1;
              count_q   <= count_q + 16'd1;
              state_q   <= ST_IDLE;
            end else begin
              state_q <= ST_MULY;
            end
          end
        end
        ST_MULY:    state_q <= ST_DIVX_GO;
        ST_DIVX_GO: state_q <= ST_DIVX;
        ST_DIVX: begin
          if (unit_done) begin
            qx_q    <= unit_res;
            state_q <= ST_MULX;
          end
        end
        ST_MULX:    state_q <= ST_DIVY_GO;
        ST_DIVY_GO: state_q <= ST_DIVY;
        ST_DIVY: begin
          if (unit_done) state_q <= ST_FIN;
        end
        ST_FIN: begin
          ofx_q     <= 32'(ext_c(px_q));
          ofy_q     <= 32'(ext_c(py_q));
          otx_q     <= 32'(ext_c(nx));
          oty_q     <= 32'(ext_c(ny));
          fin_q     <= 1'b0;
          m_valid_q <= 1'b1;
          px_q      <= nx;
          py_q      <= ny;
          count_q   <= count_q + 16'd1;
          state_q   <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {oty_q, otx_q, ofy_q, ofx_q};
  assign m_axis_tuser_o  = fin_q;

`ifndef SYNTHESIS
  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> (state_q == ST_ROOT || state_q == ST_DIVX || state_q == ST_DIVY))
    else $error("root/divide result arrived outside a wait state");

  a_advance_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !restart && count_q < limit_q) |=> (state_q == ST_SHIFT))
    else $error("moving advance did not start range reduction");

  a_finished_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && fin_q) |-> (ofx_q == otx_q && ofy_q == oty_q))
    else $error("finished beat reports a moved point");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 16'd0)
    else $error("step count wrapped to zero");
`endif

endmodule

>>> dv/tb.sv
// Self-checking bench for the square-root spiral vertex generator core.
// Depends on tsv_pkg and theodorus_spiral_vertex_generator_core; predicts each result beat
// in a small scoreboard class and compares it with the received data and finished flag.

class spiral_scoreboard;
  longint cen_x, cen_y, leg, lim;
  longint pt_x, pt_y, steps;
  logic [128:0] want_q[$];
  int errors;
  int shown;

  function new();
    cen_x = 19660800;
    cen_y = 19660800;
    leg = 3932160;
    lim = 16;
    errors = 0;
    shown = 0;
    place_first();
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function void place_first();
    pt_x = clamp32(cen_x);
    pt_y = clamp32(cen_y - leg);
    steps = 1;
  endfunction

  function void write_reg(tsv_pkg::reg_idx_e idx, logic [31:0] val);
    case (idx)
      tsv_pkg::REG_CENTER_X:   cen_x = longint'($signed(val));
      tsv_pkg::REG_CENTER_Y:   cen_y = longint'($signed(val));
      tsv_pkg::REG_LEG_LENGTH: leg = longint'(val[30:0]);
      tsv_pkg::REG_STEP_LIMIT: lim = longint'(val[15:0]);
      default: ;
    endcase
  endfunction

  function longint int_root(logic [63:0] n);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function longint leg_share(bit neg, logic [63:0] a, logic [63:0] mag);
    logic [63:0] q;
    if (mag == 0) return 0;
    q = (a * leg + mag / 2) / mag;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function void note_beat(bit restart);
    longint dx, dy, nx, ny;
    logic [63:0] ax, ay, big, mag;
    int sh;
    sh = 0;
    if (restart) begin
      place_first();
      want_q.push_back({1'b0, pt_y[31:0], pt_x[31:0], cen_y[31:0], cen_x[31:0]});
      return;
    end
    if (steps >= lim) begin
      want_q.push_back({1'b1, pt_y[31:0], pt_x[31:0], pt_y[31:0], pt_x[31:0]});
      return;
    end
    dx = pt_x - cen_x;
    dy = pt_y - cen_y;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    big = ax > ay ? ax : ay;
    while (sh < 63 && (big >> sh) >= 64'h8000_0000) sh++;
    ax >>= sh;
    ay >>= sh;
    mag = int_root(ax * ax + ay * ay);
    nx = clamp32(pt_x + leg_share(!(dy < 0), ay, mag));
    ny = clamp32(pt_y + leg_share(dx < 0, ax, mag));
    want_q.push_back({1'b0, ny[31:0], nx[31:0], pt_y[31:0], pt_x[31:0]});
    pt_x = nx;
    pt_y = ny;
    steps = (steps + 1) & 16'hFFFF;
  endfunction

  function void check_beat(logic [127:0] data, logic fin);
    logic [128:0] exp_v;
    if (want_q.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("unexpected beat data=%h fin=%b", data, fin);
      end
      return;
    end
    exp_v = want_q.pop_front();
    if (exp_v !== {fin, data}) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("mismatch exp from=(%h,%h) to=(%h,%h) fin=%b", exp_v[31:0], exp_v[63:32],
                 exp_v[95:64], exp_v[127:96], exp_v[128]);
        $display("         got from=(%h,%h) to=(%h,%h) fin=%b", data[31:0], data[63:32],
                 data[95:64], data[127:96], fin);
      end
    end
  endfunction
endclass

module tb;
  import tsv_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;

  spiral_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  always #4 clk_i = ~clk_i;

  theodorus_spiral_vertex_generator_core uut (.*);

  // receiver: random backpressure, or a forced hold
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_beat(m_axis_tdata_o, m_axis_tuser_o[0]);
      m_axis_tready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // hold valid across back-to-back beats; drop it only while idling
  task automatic send_beat(bit restart);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'($urandom_range(127)), restart};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_beat(restart);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] lg, logic [31:0] lm);
    drain();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_LEG_LENGTH, lg);
    write_reg(REG_STEP_LIMIT, lm);
  endtask

  task automatic run_random(int count);
    int n;
    for (n = 0; n < count; n++) send_beat($urandom_range(99) < 8);
  endtask

  task automatic long_hold();
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      repeat (6) send_beat(1'b0);
    join
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset settings, restart, limit reached, zero leg, extreme centers
    send_beat(1'b0);
    send_beat(1'b1);
    repeat (3) send_beat(1'b0);
    set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd4);
    send_beat(1'b1);
    repeat (4) send_beat(1'b0);
    set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
    send_beat(1'b1);
    send_beat(1'b0);
    drain();
    write_reg(REG_STEP_LIMIT, 32'hFFFF);
    repeat (3) send_beat(1'b0);
    set_all(32'd0, 32'd0, 32'd0, 32'd1);
    send_beat(1'b1);
    send_beat(1'b0);
    drain();
    write_reg(REG_STEP_LIMIT, 32'd5);
    repeat (2) send_beat(1'b0);
    set_all(32'd0, 32'd0, 32'd1, 32'hFFFF);
    send_beat(1'b1);
    repeat (3) send_beat(1'b0);

    send_idle_pct = 28;
    recv_idle_pct = 79;
    set_all(32'd19660800, 32'hFFFF_0000, 32'd65536, 32'd40);
    send_beat(1'b1);
    run_random(140);
    long_hold();

    send_idle_pct = 79;
    recv_idle_pct = 28;
    set_all($urandom, $urandom, $urandom & 32'h7FFF_FFFF, $urandom_range(65535));
    send_beat(1'b1);
    run_random(70);
    set_all($urandom_range(2000000), $urandom, $urandom_range(9000000), $urandom_range(60));
    send_beat(1'b1);
    run_random(70);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_all(32'd19660800, 32'd19660800, 32'd3932160, 32'd30);
    send_beat(1'b1);
    run_random(120);
    drain();

    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
